/* rtl/core/sma_pkg.sv */
`timescale 1ns / 1ps

package sma_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 7;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_CMP  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNDER   = 2'd1,
		ST_OVER    = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	// compare results
	localparam logic [DATA_W-1:0] CMP_GREATER = 32'd5;
	localparam logic [DATA_W-1:0] CMP_LESS    = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] CMP_EQUAL   = 32'd0;

	typedef struct packed {
		logic              start;
		action_t           op;
		logic [DATA_W-1:0] a;   // second popped value
		logic [DATA_W-1:0] b;   // first popped value (top)
	} alu_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage

/* rtl/core/sma_alu.sv */
`timescale 1ns / 1ps

module sma_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sma_pkg::alu_req_t req,
	output sma_pkg::alu_rsp_t rsp
);
	import sma_pkg::*;

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_RUN  = 3'b010,
		U_FIX  = 3'b100
	} ustate_t;

	ustate_t           state_q;
	action_t           op_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] res_q;
	logic [4:0]        cnt_q;
	logic              neg_q;
	logic              done_q;

	logic [DATA_W:0]   p_op;
	logic [DATA_W:0]   q_op;
	logic [DATA_W:0]   sum;
	logic              inv;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	assign mag_a = req.a[DATA_W-1] ? (~req.a + 32'd1) : req.a;
	assign mag_b = req.b[DATA_W-1] ? (~req.b + 32'd1) : req.b;

	// the one shared 33-bit adder
	always_comb begin
		p_op = '0;
		q_op = '0;
		inv  = 1'b0;
		if (state_q == U_FIX) begin
			q_op = {1'b0, y_q};
			inv  = neg_q;
		end else begin
			unique case (op_q)
				ACT_ADD: begin
					p_op = {x_q[DATA_W-1], x_q};
					q_op = {y_q[DATA_W-1], y_q};
				end
				ACT_SUB, ACT_CMP: begin
					p_op = {x_q[DATA_W-1], x_q};
					q_op = {y_q[DATA_W-1], y_q};
					inv  = 1'b1;
				end
				ACT_MUL: begin
					p_op = {1'b0, acc_q};
					q_op = {1'b0, x_q & {DATA_W{y_q[0]}}};
				end
				ACT_DIV: begin
					// trial subtract of the divisor from the shifted remainder
					p_op = {acc_q, y_q[DATA_W-1]};
					q_op = {1'b0, x_q};
					inv  = 1'b1;
				end
				default: begin
					p_op = '0;
				end
			endcase
		end
		sum = p_op + (q_op ^ {(DATA_W+1){inv}}) + {{DATA_W{1'b0}}, inv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= U_RUN;
					end
				end
				U_RUN: begin
					if ((op_q != ACT_MUL && op_q != ACT_DIV) || cnt_q == 5'd0) begin
						state_q <= (op_q == ACT_DIV) ? U_FIX : U_IDLE;
						done_q  <= (op_q != ACT_DIV);
					end
				end
				U_FIX: begin
					state_q <= U_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					cnt_q <= 5'd31;
					neg_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
					acc_q <= '0;
					if (req.op == ACT_DIV) begin
						x_q <= mag_b;
						y_q <= mag_a;
					end else begin
						x_q <= req.a;
						y_q <= req.b;
					end
				end
			end
			U_RUN: begin
				cnt_q <= cnt_q - 5'd1;
				unique case (op_q)
					ACT_ADD, ACT_SUB: begin
						res_q <= sum[DATA_W-1:0];
					end
					ACT_CMP: begin
						// sum is second minus first, sign-extended so it cannot overflow
						if (sum[DATA_W]) begin
							res_q <= CMP_GREATER;
						end else if (sum == '0) begin
							res_q <= CMP_EQUAL;
						end else begin
							res_q <= CMP_LESS;
						end
					end
					ACT_MUL: begin
						acc_q <= sum[DATA_W-1:0];
						x_q   <= {x_q[DATA_W-2:0], 1'b0};
						y_q   <= {1'b0, y_q[DATA_W-1:1]};
						res_q <= sum[DATA_W-1:0];
					end
					ACT_DIV: begin
						if (!sum[DATA_W]) begin
							acc_q <= sum[DATA_W-1:0];
						end else begin
							acc_q <= {acc_q[DATA_W-2:0], y_q[DATA_W-1]};
						end
						y_q <= {y_q[DATA_W-2:0], ~sum[DATA_W]};
					end
					default: begin
						res_q <= '0;
					end
				endcase
			end
			U_FIX: begin
				// apply the quotient sign
				res_q <= sum[DATA_W-1:0];
			end
			default: begin
				res_q <= '0;
			end
		endcase
	end

	assign rsp.busy   = (state_q != U_IDLE);
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

/* rtl/core/stack_machine_alu.sv */
`timescale 1ns / 1ps

// Bounded stack machine: one instruction per input transaction, one result per instruction.
// Input channel: in_valid/in_stall with action and operand. action is push, add, subtract,
// multiply, divide (truncating) or compare; operand is used only by push.
// Output channel: out_valid/out_stall with top_value (zero when empty), depth and status
// (ok, underflow, overflow, divide by zero). On any error the stack is left as it was.
// Push, underflow, overflow and unused codes go from the idle state straight to the finish state;
// divide by zero is caught in the execute state; the others start the ALU and wait for its result.
// Multiply and divide go one bit per cycle through a single shared 33-bit adder, which sets
// the rate.
// One instruction is in flight at a time: in_stall is high from acceptance until the
// result is loaded into the output register, so a new instruction is not accepted before the
// last result is loaded. A finished result waits in the output register while out_stall is high;
// the next instruction is then accepted and runs, but its result holds until the register frees.
// The stack words live in a 64-entry memory with a registered read; the top value sits in a
// register of its own. Reset (arst_n low) empties the stack and drops any pending result;
// no clearing pass is needed.

module stack_machine_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] top_value,
	output logic [6:0]         depth,
	output logic [1:0]         status
);
	import sma_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_WAIT   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t             state_q;
	action_t            act_q;
	status_t            status_q;
	logic [SP_W-1:0]    sp_q;
	logic [DATA_W-1:0]  top_q;
	logic [DATA_W-1:0]  rd_q;
	logic [DATA_W-1:0]  mem [STACK_DEPTH];
	logic               out_valid_q;
	logic [DATA_W-1:0]  top_value_q;
	logic [DEPTH_W-1:0] depth_q;
	status_t            out_status_q;

	logic               in_accept;
	logic               out_free;
	logic               stack_full;
	logic               mem_we;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	assign in_stall   = (state_q != S_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign stack_full = (sp_q >= SP_W'(STACK_DEPTH));

	// memory holds every entry below the top
	assign wr_addr = ADDR_W'(sp_q - SP_W'(1));
	assign rd_addr = ADDR_W'(sp_q - SP_W'(2));
	assign mem_we  = in_accept && (action == ACT_PUSH) && !stack_full && (sp_q != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= top_q;
		end
		rd_q <= mem[rd_addr];
	end

	assign alu_req.start = (state_q == S_EXEC) && !(act_q == ACT_DIV && top_q == '0);
	assign alu_req.op    = act_q;
	assign alu_req.a     = rd_q;
	assign alu_req.b     = top_q;

	sma_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						priority if (action == ACT_PUSH) begin
							if (!stack_full) begin
								sp_q <= sp_q + SP_W'(1);
							end
							state_q <= S_FINISH;
						end else if (action <= ACT_CMP && sp_q >= SP_W'(2)) begin
							state_q <= S_EXEC;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_EXEC: begin
					state_q <= alu_req.start ? S_WAIT : S_FINISH;
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						sp_q    <= sp_q - SP_W'(1);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					act_q    <= action_t'(action);
					status_q <= ST_OK;
					priority if (action == ACT_PUSH) begin
						if (stack_full) begin
							status_q <= ST_OVER;
						end else begin
							top_q <= operand;
						end
					end else if (action <= ACT_CMP && sp_q < SP_W'(2)) begin
						status_q <= ST_UNDER;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_EXEC: begin
				if (!alu_req.start) begin
					status_q <= ST_DIVZERO;
				end
			end
			S_WAIT: begin
				if (alu_rsp.done) begin
					top_q <= alu_rsp.result;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			top_value_q  <= (sp_q != '0) ? top_q : '0;
			depth_q      <= DEPTH_W'(sp_q);
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_value_q;
	assign depth     = depth_q;
	assign status    = out_status_q;

`ifndef SYNTHESIS
	a_sp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_sp_step: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q != $past(sp_q) |-> (sp_q == $past(sp_q) + SP_W'(1)) ||
			(sp_q == $past(sp_q) - SP_W'(1)))
		else $error("stack pointer moved by more than one");

	a_alu_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> !alu_rsp.busy)
		else $error("alu started while busy");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OVER) |-> depth == DEPTH_W'(STACK_DEPTH))
		else $error("overflow reported on a stack that is not full");
`endif

endmodule
